// File: hdl/tdq_pkg.sv
// Shared types and constants for the task dispatch queue.
package tdq_pkg;

  localparam int unsigned OpW       = 2;
  localparam int unsigned ClassW    = 2;
  localparam int unsigned IdFieldW  = 16;
  localparam int unsigned CountW    = 6;
  localparam int unsigned NumTiers  = 3;

  typedef enum logic [OpW-1:0] {
    OP_ADD       = 2'd0,
    OP_SET_READY = 2'd1,
    OP_TAKE_CPU  = 2'd2,
    OP_TAKE_GPU  = 2'd3
  } op_e;

  typedef enum logic [ClassW-1:0] {
    CLS_CPU_ONLY = 2'd0,
    CLS_CPU_PREF = 2'd1,
    CLS_GPU_PREF = 2'd2,
    CLS_GPU_ONLY = 2'd3
  } cls_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_PICK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_e;

  // Result of checking one slot against the current operation.
  typedef struct packed {
    logic                id_hit;
    logic [NumTiers-1:0] tier;
  } match_t;

endpackage

// File: hdl/tdq_in_if.sv
// Input channel of the task dispatch queue.
interface tdq_in_if;
  import tdq_pkg::*;

  logic                valid;
  logic                ready;
  logic [OpW-1:0]      operation;
  logic [IdFieldW-1:0] task_id;
  logic [ClassW-1:0]   support_class;
  logic                ready_value;

  modport source (output valid, output operation, output task_id, output support_class,
                  output ready_value, input ready);
  modport sink   (input valid, input operation, input task_id, input support_class,
                  input ready_value, output ready);
endinterface

// File: hdl/tdq_out_if.sv
// Result channel of the task dispatch queue.
interface tdq_out_if;
  import tdq_pkg::*;

  logic                valid;
  logic                ready;
  logic                taken_valid;
  logic [IdFieldW-1:0] taken_id;
  logic [ClassW-1:0]   taken_class;
  logic [CountW-1:0]   queued_count;
  logic                all_done;
  logic                add_dropped;

  modport source (output valid, output taken_valid, output taken_id, output taken_class,
                  output queued_count, output all_done, output add_dropped, input ready);
  modport sink   (input valid, input taken_valid, input taken_id, input taken_class,
                  input queued_count, input all_done, input add_dropped, output ready);
endinterface

// File: hdl/tdq_match.sv
// Slot compare unit: id match for set-ready and class tier for takes.
module tdq_match #(
  parameter int unsigned ID_WIDTH = 16
) (
  input  tdq_pkg::op_e              op_i,
  input  logic [ID_WIDTH-1:0]       key_i,
  input  logic [ID_WIDTH-1:0]       slot_id_i,
  input  logic [tdq_pkg::ClassW-1:0] slot_cls_i,
  input  logic                      slot_rdy_i,
  output tdq_pkg::match_t           match_o
);
  import tdq_pkg::*;

  always_comb begin
    match_o        = '0;
    match_o.id_hit = (op_i == OP_SET_READY) && (slot_id_i == key_i);
    unique case (op_i)
      OP_TAKE_CPU: begin
        match_o.tier[0] = slot_rdy_i &&
                          (slot_cls_i == CLS_CPU_ONLY || slot_cls_i == CLS_CPU_PREF);
        match_o.tier[1] = slot_rdy_i && (slot_cls_i == CLS_GPU_PREF);
      end
      OP_TAKE_GPU: begin
        match_o.tier[0] = slot_rdy_i && (slot_cls_i == CLS_GPU_ONLY);
        match_o.tier[1] = slot_rdy_i && (slot_cls_i == CLS_GPU_PREF);
        match_o.tier[2] = slot_rdy_i && (slot_cls_i == CLS_CPU_PREF);
      end
      default: match_o.tier = '0;
    endcase
  end

endmodule

// File: hdl/cpu_gpu_task_dispatch_queue.sv
// Task dispatch queue: packed slot memory scanned by a small sequencer.
//
// Usage: items enter on in_i (valid/ready) and each gives exactly one result
// on out_o (valid/ready). An item is operation, task_id, support_class and
// ready_value; a result reports the taken task, the queued count, all_done
// and add_dropped. Tasks sit packed at the low slots in insertion order.
// The slot memory has one read and one write port with registered read data,
// and one slot compare unit is reused for every step. The steps per item:
//   add        write the task at the next free slot (dropped when full),
//   set-ready  read and compare each slot, rewriting the ready mark of each match,
//   take       read and compare each slot, then pick; after a removal each
//              younger slot is shifted down by one. An empty queue answers
//              without a scan.
// in_i.ready is high only while the sequencer is idle; one item is worked at
// a time. A finished result is held in the output register, and the next
// item may be accepted while it waits; if that item finishes before out_o
// drains, the sequencer holds until the register frees.
// Reset empties the queue (count zero, no result pending) at once; slot
// contents are not cleared since only occupied slots are ever read.
module cpu_gpu_task_dispatch_queue #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  tdq_in_if.sink    in_i,
  tdq_out_if.source out_o
);
  import tdq_pkg::*;

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    logic [ClassW-1:0]   cls;
    logic                rdy;
  } entry_t;

  // Slot memory
  entry_t          mem [QUEUE_DEPTH];
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic [IW-1:0]   mem_raddr;
  entry_t          rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         idx_q, idx_d;
  op_e                   op_q, op_d;
  logic [ID_WIDTH-1:0]   key_q, key_d;
  logic [ClassW-1:0]     cls_q, cls_d;
  logic                  rdy_q, rdy_d;
  logic [NumTiers-1:0]   hit_q, hit_d;
  logic [IW-1:0]         hidx_q [NumTiers];
  logic [IW-1:0]         hidx_d [NumTiers];
  entry_t                hent_q [NumTiers];
  entry_t                hent_d [NumTiers];
  logic                  tk_valid_q, tk_valid_d;
  entry_t                tk_ent_q, tk_ent_d;
  logic                  drop_q, drop_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_tv_q, out_tv_d;
  logic [IdFieldW-1:0]   out_id_q, out_id_d;
  logic [ClassW-1:0]     out_cls_q, out_cls_d;
  logic [CountW-1:0]     out_cnt_q, out_cnt_d;
  logic                  out_done_q, out_done_d;
  logic                  out_drop_q, out_drop_d;

  logic                  in_fire;
  logic                  out_fire;
  logic                  out_free;
  logic [CW-1:0]         idx_inc;
  logic [ID_WIDTH+IdFieldW-1:0] key_ext;
  logic [ID_WIDTH+IdFieldW-1:0] tid_ext;
  logic [CW+CountW-1:0]  cnt_ext;
  match_t                match;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign idx_inc  = idx_q + CW'(1);
  assign key_ext  = {{ID_WIDTH{1'b0}}, in_i.task_id};
  assign tid_ext  = {{IdFieldW{1'b0}}, tk_ent_q.id};
  assign cnt_ext  = {{CountW{1'b0}}, cnt_q};

  assign in_i.ready = (state_q == ST_IDLE);

  tdq_match #(
    .ID_WIDTH(ID_WIDTH)
  ) u_match (
    .op_i      (op_q),
    .key_i     (key_q),
    .slot_id_i (rdata_q.id),
    .slot_cls_i(rdata_q.cls),
    .slot_rdy_i(rdata_q.rdy),
    .match_o   (match)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    op_d        = op_q;
    key_d       = key_q;
    cls_d       = cls_q;
    rdy_d       = rdy_q;
    hit_d       = hit_q;
    hidx_d      = hidx_q;
    hent_d      = hent_q;
    tk_valid_d  = tk_valid_q;
    tk_ent_d    = tk_ent_q;
    drop_d      = drop_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[IW-1:0];
    mem_wdata   = rdata_q;
    mem_raddr   = idx_q[IW-1:0];
    out_valid_d = out_valid_q && !out_fire;
    out_tv_d    = out_tv_q;
    out_id_d    = out_id_q;
    out_cls_d   = out_cls_q;
    out_cnt_d   = out_cnt_q;
    out_done_d  = out_done_q;
    out_drop_d  = out_drop_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d       = op_e'(in_i.operation);
          key_d      = key_ext[ID_WIDTH-1:0];
          cls_d      = in_i.support_class;
          rdy_d      = in_i.ready_value;
          idx_d      = '0;
          hit_d      = '0;
          tk_valid_d = 1'b0;
          tk_ent_d   = '0;
          drop_d     = 1'b0;
          if (op_e'(in_i.operation) == OP_ADD) begin
            state_d = ST_ADD;
          end else if (cnt_q == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_ADD: begin
        if (cnt_q == CW'(QUEUE_DEPTH)) begin
          drop_d = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cnt_q[IW-1:0];
          mem_wdata = '{id: key_q, cls: cls_q, rdy: rdy_q};
          cnt_d     = cnt_q + CW'(1);
        end
        state_d = ST_DONE;
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        // rewrite the ready mark of a matching slot in place
        if (match.id_hit) begin
          mem_we        = 1'b1;
          mem_wdata.rdy = rdy_q;
        end
        for (int t = 0; t < NumTiers; t++) begin
          if (match.tier[t] && !hit_q[t]) begin
            hit_d[t]  = 1'b1;
            hidx_d[t] = idx_q[IW-1:0];
            hent_d[t] = rdata_q;
          end
        end
        idx_d = idx_inc;
        if (idx_inc == cnt_q) begin
          state_d = (op_q == OP_SET_READY) ? ST_DONE : ST_PICK;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_PICK: begin
        state_d = ST_SHIFT_RD;
        priority if (hit_q[0]) begin
          tk_valid_d = 1'b1;
          tk_ent_d   = hent_q[0];
          idx_d      = CW'(hidx_q[0]);
        end else if (hit_q[1]) begin
          tk_valid_d = 1'b1;
          tk_ent_d   = hent_q[1];
          idx_d      = CW'(hidx_q[1]);
        end else if (hit_q[2]) begin
          tk_valid_d = 1'b1;
          tk_ent_d   = hent_q[2];
          idx_d      = CW'(hidx_q[2]);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SHIFT_RD: begin
        // advance younger slots down by one, then drop the last
        if (idx_inc >= cnt_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_DONE;
        end else begin
          mem_raddr = idx_inc[IW-1:0];
          state_d   = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        mem_we  = 1'b1;
        idx_d   = idx_inc;
        state_d = ST_SHIFT_RD;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_tv_d    = tk_valid_q;
          out_id_d    = tid_ext[IdFieldW-1:0];
          out_cls_d   = tk_ent_q.cls;
          out_cnt_d   = cnt_ext[CountW-1:0];
          out_done_d  = (cnt_q == '0);
          out_drop_d  = drop_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    op_q       <= op_d;
    key_q      <= key_d;
    cls_q      <= cls_d;
    rdy_q      <= rdy_d;
    hit_q      <= hit_d;
    hidx_q     <= hidx_d;
    hent_q     <= hent_d;
    tk_valid_q <= tk_valid_d;
    tk_ent_q   <= tk_ent_d;
    drop_q     <= drop_d;
    out_tv_q   <= out_tv_d;
    out_id_q   <= out_id_d;
    out_cls_q  <= out_cls_d;
    out_cnt_q  <= out_cnt_d;
    out_done_q <= out_done_d;
    out_drop_q <= out_drop_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.taken_valid  = out_tv_q;
  assign out_o.taken_id     = out_id_q;
  assign out_o.taken_class  = out_cls_q;
  assign out_o.queued_count = out_cnt_q;
  assign out_o.all_done     = out_done_q;
  assign out_o.add_dropped  = out_drop_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("queued count exceeds depth");

  a_gpu_never_cpu_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && op_q == OP_TAKE_GPU && tk_valid_q)
      |-> tk_ent_q.cls != CLS_CPU_ONLY)
    else $error("gpu take removed a cpu-only task");

  a_remove_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT_RD && idx_inc >= cnt_q) |=> cnt_q == $past(cnt_q) - CW'(1))
    else $error("removal did not shrink the queue by one");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD && cnt_q != CW'(QUEUE_DEPTH)) |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("add did not grow the queue by one");

endmodule
